/* hw/rtl/lcw_pkg.sv */
`timescale 1ns / 1ps

package lcw_pkg;

  // Window geometry.
  localparam int MAX_HALF_WINDOW = 7;
  localparam int LEGS            = 6;
  localparam int DEPTH           = 2 * MAX_HALF_WINDOW + 1;

  // Fixed field widths.
  localparam int LEG_PORTS = 6;
  localparam int RAW_W     = 11;
  localparam int CFG_W     = 3;
  localparam int MASK_W    = 6;

  // Decoded load value in -1023..1024.
  localparam int VAL_W         = 12;
  localparam int NO_REPLY_LOAD = 1024;

  // Adder tree: groups of four history entries, then one sum of the groups.
  localparam int GROUP_SIZE = 4;
  localparam int GROUPS     = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PART_W     = VAL_W + $clog2(GROUP_SIZE);
  localparam int SUM_W      = VAL_W + $clog2(DEPTH + 1);

  // Counter and index widths.
  localparam int AGE_W = $clog2(DEPTH);
  localparam int HW_W  = $clog2(MAX_HALF_WINDOW + 1);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic             shift;
    logic             clear;
    logic             part_en;
    logic [AGE_W-1:0] hi;
  } lane_ctrl_t;

  typedef struct packed {
    logic load;
    logic last;
  } merge_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PART = 3'b010,
    ST_EMIT = 3'b100
  } seq_state_e;

endpackage

/* hw/rtl/lcw_lane.sv */
`timescale 1ns / 1ps

// One leg: load decoding, the history shift line and a two-level adder tree.
module lcw_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lcw_pkg::lane_ctrl_t            ctrl_i,
  input  logic [lcw_pkg::RAW_W-1:0]      raw_i,
  input  logic                           answered_i,
  output logic                           contact_o
);

  logic signed [lcw_pkg::VAL_W-1:0]  decoded;
  logic signed [lcw_pkg::VAL_W-1:0]  hist_q [lcw_pkg::DEPTH];
  logic signed [lcw_pkg::VAL_W-1:0]  masked [lcw_pkg::GROUPS * lcw_pkg::GROUP_SIZE];
  logic signed [lcw_pkg::PART_W-1:0] part_d [lcw_pkg::GROUPS];
  logic signed [lcw_pkg::PART_W-1:0] part_q [lcw_pkg::GROUPS];
  logic signed [lcw_pkg::SUM_W-1:0]  sum;
  logic signed [lcw_pkg::VAL_W-1:0]  raw_ext;

  assign raw_ext = lcw_pkg::VAL_W'({1'b0, raw_i});

  always_comb begin
    if (!answered_i) begin
      decoded = lcw_pkg::VAL_W'(lcw_pkg::NO_REPLY_LOAD);
    end else if (raw_ext > lcw_pkg::VAL_W'(lcw_pkg::NO_REPLY_LOAD)) begin
      decoded = lcw_pkg::VAL_W'(lcw_pkg::NO_REPLY_LOAD) - raw_ext;
    end else begin
      decoded = raw_ext;
    end
  end

  // Newest sample at age zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < lcw_pkg::DEPTH; a++) hist_q[a] <= '0;
    end else if (ctrl_i.clear) begin
      for (int a = 0; a < lcw_pkg::DEPTH; a++) hist_q[a] <= '0;
    end else if (ctrl_i.shift) begin
      hist_q[0] <= decoded;
      for (int a = 1; a < lcw_pkg::DEPTH; a++) hist_q[a] <= hist_q[a-1];
    end
  end

  // Entries older than the top of the window are masked to zero.
  for (genvar i = 0; i < lcw_pkg::GROUPS * lcw_pkg::GROUP_SIZE; i++) begin : g_mask
    if (i < lcw_pkg::DEPTH) begin : g_tap
      assign masked[i] = (lcw_pkg::AGE_W'(i) <= ctrl_i.hi) ? hist_q[i] : '0;
    end else begin : g_pad
      assign masked[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < lcw_pkg::GROUPS; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < lcw_pkg::GROUP_SIZE; k++) begin
        part_d[g] = part_d[g] + lcw_pkg::PART_W'(masked[g * lcw_pkg::GROUP_SIZE + k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.part_en) begin
      for (int g = 0; g < lcw_pkg::GROUPS; g++) part_q[g] <= part_d[g];
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < lcw_pkg::GROUPS; g++) begin
      sum = sum + lcw_pkg::SUM_W'(part_q[g]);
    end
  end

  assign contact_o = sum[lcw_pkg::SUM_W-1] || (sum == '0);

endmodule

/* hw/rtl/lcw_merge.sv */
`timescale 1ns / 1ps

// Gathers the lane decisions into one contact mask and holds it for the consumer.
module lcw_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcw_pkg::merge_ctrl_t        ctrl_i,
  input  logic [lcw_pkg::LEGS-1:0]    contacts_i,
  output logic                        slot_free_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lcw_pkg::MASK_W-1:0]  contact_mask_o,
  output logic                        last_result_o
);

  logic                        valid_d, valid_q;
  logic [lcw_pkg::MASK_W-1:0]  mask_q;
  logic                        last_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    if (ctrl_i.load) begin
      valid_d = 1'b1;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Legs beyond the lane count report no contact.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      mask_q <= lcw_pkg::MASK_W'(contacts_i);
      last_q <= ctrl_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign contact_mask_o = mask_q;
  assign last_result_o  = last_q;

endmodule

/* hw/rtl/leg_contact_window_classifier.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        consumer   in_valid_i / in_stall_o load_0_i..load_5_i, answered_mask_i,
//                                              last_sample_i
// out       producer   out_valid_o/out_stall_i contact_mask_o, last_result_o
// config    write only half_window_we_i        half_window_i
//
// An input transaction that produces no result is taken in the idle step. One that
// produces results passes through a partial-sum step and an emit step per result,
// so the last sample of a recording with n pending centres gives n such pairs, set
// by the two-level registered adder tree in each lane that the sequencer reuses for
// every result. Reset clears the history, the sample count and the output valid flag,
// and loads a half window of two. A stalled output holds the sequencer in its emit
// step; a new input transaction is still accepted while the last result waits.
module leg_contact_window_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        half_window_we_i,
  input  logic [lcw_pkg::CFG_W-1:0]   half_window_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lcw_pkg::RAW_W-1:0]   load_0_i,
  input  logic [lcw_pkg::RAW_W-1:0]   load_1_i,
  input  logic [lcw_pkg::RAW_W-1:0]   load_2_i,
  input  logic [lcw_pkg::RAW_W-1:0]   load_3_i,
  input  logic [lcw_pkg::RAW_W-1:0]   load_4_i,
  input  logic [lcw_pkg::RAW_W-1:0]   load_5_i,
  input  logic [lcw_pkg::MASK_W-1:0]  answered_mask_i,
  input  logic                        last_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lcw_pkg::MASK_W-1:0]  contact_mask_o,
  output logic                        last_result_o
);

  // The half window register; its reset value is two.
  logic [lcw_pkg::CFG_W-1:0] half_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q <= lcw_pkg::CFG_W'(2);
    end else if (half_window_we_i) begin
      half_window_q <= half_window_i;
    end
  end

  // A half window above the supported maximum is clamped to it.
  logic [lcw_pkg::HW_W-1:0] lw;
  assign lw = (int'(half_window_q) > lcw_pkg::MAX_HALF_WINDOW) ?
              lcw_pkg::HW_W'(lcw_pkg::MAX_HALF_WINDOW) : lcw_pkg::HW_W'(half_window_q);

  // Sequencer state.
  lcw_pkg::seq_state_e       state_d, state_q;
  logic [lcw_pkg::CNT_W-1:0] count_d, count_q;
  logic [lcw_pkg::AGE_W-1:0] hi_d, hi_q;
  logic [lcw_pkg::HW_W-1:0]  centre_d, centre_q;
  logic                      flush_d, flush_q;

  logic                      in_accept;
  logic [lcw_pkg::CNT_W-1:0] held;
  logic [lcw_pkg::CNT_W-1:0] held_m1;
  logic [lcw_pkg::HW_W-1:0]  top;
  logic                      slot_free;

  lcw_pkg::lane_ctrl_t  lane_ctrl;
  lcw_pkg::merge_ctrl_t merge_ctrl;

  assign in_stall_o = (state_q != lcw_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // The count of held samples saturates at the history depth.
  assign held    = (count_q < lcw_pkg::CNT_W'(lcw_pkg::DEPTH)) ? count_q + 1'b1 : count_q;
  assign held_m1 = held - 1'b1;
  assign top     = (lcw_pkg::CNT_W'(lw) < held_m1) ? lw : lcw_pkg::HW_W'(held_m1);

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    hi_d            = hi_q;
    centre_d        = centre_q;
    flush_d         = flush_q;
    lane_ctrl       = '0;
    lane_ctrl.hi    = hi_q;
    merge_ctrl      = '0;
    merge_ctrl.last = flush_q && (centre_q == '0);

    case (state_q)
      lcw_pkg::ST_IDLE: begin
        if (in_accept) begin
          lane_ctrl.shift = 1'b1;
          if (last_sample_i) begin
            // Flush: centres from top samples old down to the newest. The window
            // reaches past the newest sample only into zeroed history, so the upper
            // age of each window is simply its centre plus the half window.
            count_d  = '0;
            flush_d  = 1'b1;
            centre_d = top;
            hi_d     = lcw_pkg::AGE_W'(top) + lcw_pkg::AGE_W'(lw);
            state_d  = lcw_pkg::ST_PART;
          end else begin
            count_d  = held;
            flush_d  = 1'b0;
            centre_d = '0;
            hi_d     = lcw_pkg::AGE_W'(lw) + lcw_pkg::AGE_W'(lw);
            if (lcw_pkg::CNT_W'(lw) < held) begin
              state_d = lcw_pkg::ST_PART;
            end
          end
        end
      end
      lcw_pkg::ST_PART: begin
        lane_ctrl.part_en = 1'b1;
        state_d           = lcw_pkg::ST_EMIT;
      end
      lcw_pkg::ST_EMIT: begin
        if (slot_free) begin
          merge_ctrl.load = 1'b1;
          if (flush_q && (centre_q != '0)) begin
            centre_d = centre_q - 1'b1;
            hi_d     = hi_q - 1'b1;
            state_d  = lcw_pkg::ST_PART;
          end else begin
            // The recording has ended: the next sample starts from empty history.
            lane_ctrl.clear = flush_q;
            state_d         = lcw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lcw_pkg::ST_IDLE;
      count_q  <= '0;
      hi_q     <= '0;
      centre_q <= '0;
      flush_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      hi_q     <= hi_d;
      centre_q <= centre_d;
      flush_q  <= flush_d;
    end
  end

  // One lane per leg.
  logic [lcw_pkg::RAW_W-1:0] raw [lcw_pkg::LEG_PORTS];
  logic [lcw_pkg::LEGS-1:0]  contacts;

  assign raw[0] = load_0_i;
  assign raw[1] = load_1_i;
  assign raw[2] = load_2_i;
  assign raw[3] = load_3_i;
  assign raw[4] = load_4_i;
  assign raw[5] = load_5_i;

  for (genvar g = 0; g < lcw_pkg::LEGS; g++) begin : g_lane
    lcw_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .raw_i      (raw[g]),
      .answered_i (answered_mask_i[g]),
      .contact_o  (contacts[g])
    );
  end

  lcw_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (merge_ctrl),
    .contacts_i     (contacts),
    .slot_free_o    (slot_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .contact_mask_o (contact_mask_o),
    .last_result_o  (last_result_o)
  );

  // The emit step always directly follows the partial-sum step of the adder tree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lcw_pkg::ST_PART |=> state_q == lcw_pkg::ST_EMIT)
    else $error("partial sums not followed by an emit step");

  // The last sample of a recording always produces at least one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last_sample_i |=> state_q == lcw_pkg::ST_PART && flush_q)
    else $error("last sample did not start a flush");

  // A result is only loaded into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_ctrl.load |-> state_q == lcw_pkg::ST_EMIT && slot_free)
    else $error("result loaded outside the emit step or over a waiting result");

  // The final result of a recording leaves the sample count empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_ctrl.load && merge_ctrl.last |=> count_q == '0 && state_q == lcw_pkg::ST_IDLE)
    else $error("recording not closed after its final result");

  // The held count never passes the history depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= lcw_pkg::CNT_W'(lcw_pkg::DEPTH))
    else $error("sample count beyond history depth");

endmodule
